// ===== rtl/prsmc_pkg.sv =====
// Package: shared types and constants for the per-row substring match counter.
`timescale 1ns / 1ps
package prsmc_pkg;

	// Field widths fixed by the stream format
	localparam int SYMBOL_W   = 8;
	localparam int ROW_W      = 4;
	localparam int TILE_W     = 12;
	localparam int LEN_W      = 5;
	localparam int LINE_W     = 17;
	localparam int TOTAL_W    = 32;
	localparam int PWORD_W    = 64;
	localparam int ROW_SLOTS  = 1 << ROW_W;
	localparam int PIDX_W     = 4;

	// APB geometry: three 64-bit registers at 8-byte spacing
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 5;
	localparam int REG_SEL_W  = 2;

	// Input and result stream packing
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 56;

	// Register indexes
	typedef enum logic [REG_SEL_W-1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_PATTERN_LOW    = 2'd1,
		REG_PATTERN_HIGH   = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_sel_t;

	// Programmed pattern
	typedef struct packed {
		logic [LEN_W-1:0]   pattern_length;
		logic [PWORD_W-1:0] pattern_chars_low;
		logic [PWORD_W-1:0] pattern_chars_high;
	} cfg_t;

	// One text character with its position
	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic [ROW_W-1:0]    row_in_tile;
		logic [TILE_W-1:0]   tile_row;
		logic                clear_progress;
	} item_t;

	// One result
	typedef struct packed {
		logic               match_found;
		logic [LINE_W-1:0]  line_number;
		logic [TOTAL_W-1:0] match_total;
	} result_t;

	// Pick pattern byte idx out of the two pattern words.
	function automatic logic [SYMBOL_W-1:0] pattern_byte(input cfg_t cfg,
			input logic [PIDX_W-1:0] idx);
		logic [PWORD_W-1:0] word;
		word = idx[PIDX_W-1] ? cfg.pattern_chars_high : cfg.pattern_chars_low;
		return word[idx[PIDX_W-2:0]*SYMBOL_W +: SYMBOL_W];
	endfunction

endpackage

// ===== rtl/prsmc_core.sv =====
// Match engine: per-row progress table, compare and update, saturating total.
`timescale 1ns / 1ps
module prsmc_core import prsmc_pkg::*; #(
	parameter int ROWS_PER_TILE = 16,
	parameter int MAX_PATTERN   = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    advance,
	output result_t result
);

	localparam int RptW  = $clog2(ROWS_PER_TILE + 1);
	localparam int ProdW = TILE_W + RptW;
	localparam int SumW  = (ProdW + 1 > LINE_W) ? ProdW + 1 : LINE_W;

	logic [LEN_W-1:0]   row_progress_q [ROW_SLOTS];
	logic [TOTAL_W-1:0] matches_seen_q;

	logic [LEN_W-1:0]    len_eff;
	logic [LEN_W-1:0]    prog_raw;
	logic [LEN_W-1:0]    prog;
	logic [LEN_W-1:0]    prog_inc;
	logic [LEN_W-1:0]    prog_next;
	logic [LEN_W-1:0]    restart;
	logic                hit;
	logic [SumW-1:0]     line_sum;
	logic [TOTAL_W-1:0]  total_next;

	// Clamp the programmed length into 1..MAX_PATTERN.
	always_comb begin
		if (cfg.pattern_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = cfg.pattern_length;
		end
	end

	// Compare the character with the next expected pattern byte.
	always_comb begin
		restart  = (item.symbol == pattern_byte(cfg, '0)) ? LEN_W'(1) : '0;
		prog_raw = item.clear_progress ? '0 : row_progress_q[item.row_in_tile];
		prog     = (prog_raw >= len_eff) ? '0 : prog_raw;
		prog_inc = prog + LEN_W'(1);
		hit      = 1'b0;
		if (item.symbol == pattern_byte(cfg, prog[PIDX_W-1:0])) begin
			if (prog_inc == len_eff) begin
				hit       = 1'b1;
				prog_next = restart;
			end else begin
				prog_next = prog_inc;
			end
		end else begin
			prog_next = restart;
		end
	end

	// Running total, held at its maximum once reached.
	always_comb begin
		if (hit && (matches_seen_q != '1)) begin
			total_next = matches_seen_q + TOTAL_W'(1);
		end else begin
			total_next = matches_seen_q;
		end
	end

	// Global line number of this character.
	assign line_sum = SumW'(item.tile_row) * SumW'(ROWS_PER_TILE)
		+ SumW'(item.row_in_tile) + SumW'(1);

	assign result.match_found = hit;
	assign result.line_number = hit ? line_sum[LINE_W-1:0] : '0;
	assign result.match_total = total_next;

	// State update when the item moves on to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROW_SLOTS; i++) begin
				row_progress_q[i] <= '0;
			end
			matches_seen_q <= '0;
		end else if (advance) begin
			row_progress_q[item.row_in_tile] <= prog_next;
			matches_seen_q                   <= total_next;
		end
	end

endmodule

// ===== rtl/per_row_substring_match_counter.sv =====
// Top level: APB pattern registers, input register, match engine, result register.
//
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tdata: symbol, row_in_tile, tile_row; tuser: clear
// m_axis    out        m_axis_tvalid/tready      tdata: line_number, match_total; tuser: match_found
// apb       in         psel/penable/pready       pattern_length @0, chars_low @8, chars_high @16
//
// One character per cycle is sustained while m_axis keeps accepting. The progress-table read,
// compare and update happen while the character sits in the input register; its result
// then moves into the result register, from which it is offered on m_axis.
// Reset clears the progress table, the total and both stage valids; the pattern
// registers return to length 1 and zero characters. A stall on m_axis holds the
// result register and backs up into the input register before s_axis_tready falls.
`timescale 1ns / 1ps
module per_row_substring_match_counter import prsmc_pkg::*; #(
	parameter int ROWS_PER_TILE = 16,
	parameter int MAX_PATTERN   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// APB configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	// Input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // symbol[7:0], row_in_tile[11:8], tile_row[23:12]
	input  logic                   s_axis_tuser,  // clear_progress
	// Result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // line_number[16:0], match_total[48:17], zeros
	output logic                   m_axis_tuser   // match_found
);

	cfg_t     cfg_q;
	reg_sel_t reg_sel;
	logic     cfg_write;

	item_t    item_s1;
	logic     valid_s1;
	result_t  result_s2;
	logic     valid_s2;
	result_t  core_result;
	logic     advance;
	logic     in_take;

	// APB register file; writes complete in the access phase.
	assign pready    = 1'b1;
	assign reg_sel   = reg_sel_t'(paddr[APB_ADDR_W-1 -: REG_SEL_W]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_length     <= LEN_W'(1);
			cfg_q.pattern_chars_low  <= '0;
			cfg_q.pattern_chars_high <= '0;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_PATTERN_LENGTH: cfg_q.pattern_length     <= pwdata[LEN_W-1:0];
				REG_PATTERN_LOW:    cfg_q.pattern_chars_low  <= pwdata;
				REG_PATTERN_HIGH:   cfg_q.pattern_chars_high <= pwdata;
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_sel)
			REG_PATTERN_LENGTH: prdata = APB_DATA_W'(cfg_q.pattern_length);
			REG_PATTERN_LOW:    prdata = cfg_q.pattern_chars_low;
			REG_PATTERN_HIGH:   prdata = cfg_q.pattern_chars_high;
			default:            prdata = '0;
		endcase
	end

	// Handshake: the input register moves on whenever the result register is empty or its result is taken.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Input register captures each accepted transaction.
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.symbol         <= s_axis_tdata[SYMBOL_W-1:0];
			item_s1.row_in_tile    <= s_axis_tdata[SYMBOL_W +: ROW_W];
			item_s1.tile_row       <= s_axis_tdata[SYMBOL_W+ROW_W +: TILE_W];
			item_s1.clear_progress <= s_axis_tuser;
		end
	end

	prsmc_core #(
		.ROWS_PER_TILE (ROWS_PER_TILE),
		.MAX_PATTERN   (MAX_PATTERN)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (item_s1),
		.advance (advance),
		.result  (core_result)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = result_s2.match_found;
	assign m_axis_tdata  = {
		{(OUT_TDATA_W - LINE_W - TOTAL_W){1'b0}},
		result_s2.match_total,
		result_s2.line_number
	};

endmodule

// ===== sim/tb_per_row_substring_match_counter.sv =====
// Testbench for the per-row substring match counter: directed table, then random text.
`timescale 1ns / 1ps
module tb_per_row_substring_match_counter import prsmc_pkg::*;;

	localparam int TILE_ROWS     = 16;
	localparam int PATTERN_MAX   = 16;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 119;

	// One row of the directed table: either a register write or a text character.
	typedef struct packed {
		logic                  cfg_write;
		reg_sel_t              sel;
		logic [APB_DATA_W-1:0] value;
		item_t                 text;
		logic                  typed;
		result_t               want;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;  // symbol[7:0], row_in_tile[11:8], tile_row[23:12]
	logic                   s_axis_tuser;  // clear_progress
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // line_number[16:0], match_total[48:17], zeros
	logic                   m_axis_tuser;  // match_found

	// Model copy of the pattern registers and of the per-row progress.
	logic [LEN_W-1:0]   len_reg;
	logic [PWORD_W-1:0] chars_lo;
	logic [PWORD_W-1:0] chars_hi;
	logic [LEN_W-1:0]   depth [ROW_SLOTS];
	logic [TOTAL_W-1:0] hits;

	// Results still owed by the block, oldest first.
	result_t awaited[$];

	int fails = 0;
	int idle_cycles = 0;
	bit send_quiet = 1'b0;
	bit take_quiet = 1'b0;

	per_row_substring_match_counter #(
		.ROWS_PER_TILE(TILE_ROWS),
		.MAX_PATTERN(PATTERN_MAX)
	) dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Effective pattern length: zero acts as one, anything over the maximum as the maximum.
	function automatic int span_of();
		int n;
		n = int'(len_reg);
		if (n < 1) n = 1;
		if (n > PATTERN_MAX) n = PATTERN_MAX;
		return n;
	endfunction

	function automatic logic [7:0] pat_char(input int idx);
		logic [2*PWORD_W-1:0] both;
		both = {chars_hi, chars_lo};
		return both[8*idx +: 8];
	endfunction

	// Advance the model by one character and return the result it must produce.
	function automatic result_t scan_symbol(input item_t it);
		int span;
		int prog;
		logic [7:0] first;
		result_t r;
		span = span_of();
		first = pat_char(0);
		r = '0;
		if (it.clear_progress) depth[it.row_in_tile] = '0;
		prog = int'(depth[it.row_in_tile]);
		// Progress left over from a longer pattern counts as none.
		if (prog >= span) prog = 0;
		if (it.symbol == pat_char(prog)) begin
			prog++;
			if (prog == span) begin
				r.match_found = 1'b1;
				prog = (it.symbol == first) ? 1 : 0;
			end
		end else begin
			prog = (it.symbol == first) ? 1 : 0;
		end
		depth[it.row_in_tile] = prog[LEN_W-1:0];
		if (r.match_found && hits != '1) hits++;
		if (r.match_found)
			r.line_number = LINE_W'(it.tile_row * TILE_ROWS + it.row_in_tile + 1);
		r.match_total = hits;
		return r;
	endfunction

	function automatic plan_row_t text_row(input logic [7:0] sym, input logic [3:0] row,
			input logic [11:0] tile, input logic clr, input logic typed,
			input logic found, input logic [LINE_W-1:0] line,
			input logic [TOTAL_W-1:0] total);
		plan_row_t p;
		p = '0;
		p.text.symbol = sym;
		p.text.row_in_tile = row;
		p.text.tile_row = tile;
		p.text.clear_progress = clr;
		p.typed = typed;
		p.want.match_found = found;
		p.want.line_number = line;
		p.want.match_total = total;
		return p;
	endfunction

	function automatic plan_row_t cfg_row(input reg_sel_t sel,
			input logic [APB_DATA_W-1:0] value);
		plan_row_t p;
		p = '0;
		p.cfg_write = 1'b1;
		p.sel = sel;
		p.value = value;
		return p;
	endfunction

	task automatic flag(input string what, input longint unsigned exp,
			input longint unsigned act);
		fails++;
		if (fails <= 10)
			$display("mismatch in %s: expected 0x%0h, got 0x%0h", what, exp, act);
	endtask

	// Register write: setup cycle, then access cycle; the model follows at the write edge.
	task automatic apb_write(input reg_sel_t sel, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (sel)
			REG_PATTERN_LENGTH: len_reg = value[LEN_W-1:0];
			REG_PATTERN_LOW: chars_lo = value;
			REG_PATTERN_HIGH: chars_hi = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one character, wait for its transaction and record what it must produce.
	task automatic send_text(input item_t it, input logic typed, input result_t want);
		int gap;
		result_t r;
		gap = send_quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {it.tile_row, it.row_in_tile, it.symbol};
		s_axis_tuser <= it.clear_progress;
		do @(posedge clk); while (!s_axis_tready);
		r = scan_symbol(it);
		awaited.push_back(typed ? want : r);
	endtask

	// Hold the input stream until every owed result has come back.
	task automatic wait_results_out();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited.size() != 0) @(posedge clk);
	endtask

	// Result side: random stalls, then compare each transaction with the oldest expectation.
	initial begin
		int gap;
		result_t want;
		logic [LINE_W-1:0] line;
		logic [TOTAL_W-1:0] total;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 24) == 0) take_quiet = !take_quiet;
			gap = take_quiet ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			line = m_axis_tdata[LINE_W-1:0];
			total = m_axis_tdata[LINE_W +: TOTAL_W];
			if (awaited.size() == 0) begin
				flag("result with nothing awaited", 0, {m_axis_tuser, m_axis_tdata});
			end else begin
				want = awaited.pop_front();
				if (m_axis_tuser !== want.match_found)
					flag("match_found", want.match_found, m_axis_tuser);
				if (line !== want.line_number)
					flag("line_number", want.line_number, line);
				if (total !== want.match_total)
					flag("match_total", want.match_total, total);
			end
		end
	end

	// Watchdog: too long without any transaction on any port ends the run.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: directed table first, then random phases under changing patterns.
	initial begin
		plan_row_t plan[$];
		int cursor [ROW_SLOTS];
		int phase_len [PHASES];
		int ph;
		int n;
		int span;
		int pick;
		int rows_used;
		int row;
		bit narrow;
		item_t it;
		logic [APB_DATA_W-1:0] word;
		logic [2*PWORD_W-1:0] chars;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		len_reg = 1;
		chars_lo = '0;
		chars_hi = '0;
		for (n = 0; n < ROW_SLOTS; n++) depth[n] = '0;
		hits = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// After reset the pattern is a single zero byte, so every zero byte matches.
		plan.push_back(text_row(8'h00, 4'd0, 12'd0, 1'b0, 1'b1, 1'b1, 17'd1, 32'd1));
		plan.push_back(text_row(8'hFF, 4'd15, 12'd4095, 1'b1, 1'b1, 1'b0, 17'd0, 32'd1));
		plan.push_back(text_row(8'h00, 4'd15, 12'd4095, 1'b0, 1'b1, 1'b1, 17'h10000, 32'd2));
		// A zero length, with junk above the field, behaves as length one.
		plan.push_back(cfg_row(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0));
		plan.push_back(cfg_row(REG_PATTERN_LOW, 64'h0000_0000_0000_00FF));
		plan.push_back(text_row(8'hFF, 4'd3, 12'd0, 1'b0, 1'b1, 1'b1, 17'd4, 32'd3));
		plan.push_back(text_row(8'hFE, 4'd3, 12'd0, 1'b0, 1'b1, 1'b0, 17'd0, 32'd3));
		// A write past the register map must leave the pattern alone.
		plan.push_back(cfg_row(REG_UNUSED, '1));
		plan.push_back(text_row(8'hFF, 4'd3, 12'd0, 1'b0, 1'b1, 1'b1, 17'd4, 32'd4));
		// Pattern "aab": "aaab" is missed for want of backtracking, the next "aab" is found.
		plan.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd3));
		plan.push_back(cfg_row(REG_PATTERN_LOW, 64'h0000_0000_0062_6161));
		plan.push_back(cfg_row(REG_PATTERN_HIGH, '1));
		plan.push_back(text_row(8'h61, 4'd2, 12'd7, 1'b0, 1'b0, 1'b0, '0, '0));
		plan.push_back(text_row(8'h61, 4'd2, 12'd7, 1'b0, 1'b0, 1'b0, '0, '0));
		plan.push_back(text_row(8'h61, 4'd2, 12'd7, 1'b0, 1'b0, 1'b0, '0, '0));
		plan.push_back(text_row(8'h62, 4'd2, 12'd7, 1'b0, 1'b0, 1'b0, '0, '0));
		plan.push_back(text_row(8'h61, 4'd2, 12'd7, 1'b0, 1'b0, 1'b0, '0, '0));
		plan.push_back(text_row(8'h61, 4'd2, 12'd7, 1'b0, 1'b0, 1'b0, '0, '0));
		plan.push_back(text_row(8'h62, 4'd2, 12'd7, 1'b0, 1'b0, 1'b0, '0, '0));
		// Row 5 reaches progress 2, which turns stale when the length drops to 2.
		plan.push_back(text_row(8'h61, 4'd5, 12'd100, 1'b0, 1'b0, 1'b0, '0, '0));
		plan.push_back(text_row(8'h61, 4'd5, 12'd100, 1'b0, 1'b0, 1'b0, '0, '0));
		plan.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd2));
		plan.push_back(text_row(8'h61, 4'd5, 12'd100, 1'b0, 1'b0, 1'b0, '0, '0));
		plan.push_back(text_row(8'h61, 4'd5, 12'd100, 1'b0, 1'b0, 1'b0, '0, '0));
		// The clear flag drops partial progress before the compare.
		plan.push_back(text_row(8'h61, 4'd6, 12'd4095, 1'b0, 1'b0, 1'b0, '0, '0));
		plan.push_back(text_row(8'h61, 4'd6, 12'd4095, 1'b1, 1'b0, 1'b0, '0, '0));
		plan.push_back(text_row(8'h61, 4'd6, 12'd4095, 1'b0, 1'b0, 1'b0, '0, '0));

		foreach (plan[i]) begin
			if (plan[i].cfg_write) begin
				wait_results_out();
				apb_write(plan[i].sel, plan[i].value);
			end else begin
				send_text(plan[i].text, plan[i].typed, plan[i].want);
			end
		end

		// Random phases: each sets a new pattern once the block is idle.
		phase_len = '{1, 16, 0, 31, 17, 2, 3, 0};
		phase_len[PHASES-1] = $urandom_range(0, 31);
		for (ph = 0; ph < PHASES; ph++) begin
			wait_results_out();
			narrow = (ph % 3 == 1);
			if (narrow) begin
				for (n = 0; n < 2 * PATTERN_MAX; n += 2) begin
					chars[4*n +: 8] = 8'(32'h61 + $urandom_range(0, 1));
				end
			end else begin
				chars = {$urandom(), $urandom(), $urandom(), $urandom()};
			end
			word = {$urandom(), $urandom()};
			word[LEN_W-1:0] = LEN_W'(phase_len[ph]);
			apb_write(REG_PATTERN_LENGTH, word);
			apb_write(REG_PATTERN_LOW, chars[PWORD_W-1:0]);
			apb_write(REG_PATTERN_HIGH, chars[2*PWORD_W-1:PWORD_W]);
			if (ph == 3) apb_write(REG_UNUSED, {$urandom(), $urandom()});
			send_quiet = ph[0];
			rows_used = $urandom_range(1, ROW_SLOTS);
			for (n = 0; n < ROW_SLOTS; n++) cursor[n] = 0;
			span = span_of();
			// Mostly the pattern written in order per row, interleaved across rows, with noise.
			for (n = 0; n < PHASE_ITEMS; n++) begin
				it = '0;
				row = ($urandom_range(0, 19) == 0) ? $urandom_range(0, ROW_SLOTS - 1) :
						$urandom_range(0, rows_used - 1);
				it.row_in_tile = ROW_W'(row);
				it.tile_row = TILE_W'($urandom_range(0, 4095));
				it.clear_progress = ($urandom_range(0, 24) == 0);
				if (it.clear_progress) cursor[row] = 0;
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					it.symbol = pat_char(cursor[row]);
					cursor[row] = (cursor[row] + 1) % span;
				end else if (pick < 90) begin
					it.symbol = pat_char(0);
					cursor[row] = 1 % span;
				end else begin
					it.symbol = (narrow && pick < 97) ?
							SYMBOL_W'(32'h61 + $urandom_range(0, 1)) :
							SYMBOL_W'($urandom_range(0, 255));
					cursor[row] = 0;
				end
				send_text(it, 1'b0, '0);
			end
		end

		wait_results_out();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
